@@ hw/rtl/sts_pkg.sv @@
// Package: token kinds, scan modes and the token and group types shared by the scanner modules.
`timescale 1ns / 1ps

package sts_pkg;

    // Token kinds
    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACK   = 6'd2;
    localparam logic [5:0] K_RBRACK   = 6'd3;
    localparam logic [5:0] K_LBRACE   = 6'd4;
    localparam logic [5:0] K_RBRACE   = 6'd5;
    localparam logic [5:0] K_COMMA    = 6'd6;
    localparam logic [5:0] K_DOT      = 6'd7;
    localparam logic [5:0] K_MINUS    = 6'd8;
    localparam logic [5:0] K_PLUS     = 6'd9;
    localparam logic [5:0] K_SLASH    = 6'd10;
    localparam logic [5:0] K_STAR     = 6'd11;
    localparam logic [5:0] K_BANG     = 6'd12;
    localparam logic [5:0] K_EQ       = 6'd14;
    localparam logic [5:0] K_GT       = 6'd16;
    localparam logic [5:0] K_LT       = 6'd18;
    localparam logic [5:0] K_IDENT    = 6'd20;
    localparam logic [5:0] K_STRING   = 6'd21;
    localparam logic [5:0] K_NUMBER   = 6'd22;
    localparam logic [5:0] K_KW0      = 6'd23;
    localparam logic [5:0] K_EOF      = 6'd39;
    localparam logic [5:0] K_ERR_CHAR = 6'd40;
    localparam logic [5:0] K_ERR_STR  = 6'd41;

    // Pending operator codes
    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_BANG = 3'd1;
    localparam logic [2:0] P_EQ   = 3'd2;
    localparam logic [2:0] P_LT   = 3'd3;
    localparam logic [2:0] P_GT   = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_OP, M_STR, M_COMMENT
    } mode_t;

    // One token as it leaves the scanner
    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } tok_t;

    // Up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
        tok_t       t2;
    } grp_t;

    // Keyword text, padded with zeros, and lengths
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [47:0] s;
        unique case (k)
            4'd0:  s = {"and", 24'd0};
            4'd1:  s = {"class", 8'd0};
            4'd2:  s = {"else", 16'd0};
            4'd3:  s = {"false", 8'd0};
            4'd4:  s = {"for", 24'd0};
            4'd5:  s = {"fun", 24'd0};
            4'd6:  s = {"if", 32'd0};
            4'd7:  s = {"nil", 24'd0};
            4'd8:  s = {"or", 32'd0};
            4'd9:  s = {"print", 8'd0};
            4'd10: s = "return";
            4'd11: s = {"super", 8'd0};
            4'd12: s = {"this", 16'd0};
            4'd13: s = {"true", 16'd0};
            4'd14: s = {"var", 24'd0};
            default: s = {"while", 8'd0};
        endcase
        kw_char = (p > 3'd5) ? 8'd0 : s[47 - 8 * p -: 8];
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        unique case (k)
            4'd6, 4'd8: kw_len = 3'd2;
            4'd0, 4'd4, 4'd5, 4'd7, 4'd14: kw_len = 3'd3;
            4'd2, 4'd12, 4'd13: kw_len = 3'd4;
            4'd10: kw_len = 3'd6;
            default: kw_len = 3'd5;
        endcase
    endfunction

endpackage

@@ hw/rtl/sts_front.sv @@
// Front end: scanner state, keyword tracking and token formation for each byte.
`timescale 1ns / 1ps

module sts_front #(
    parameter logic [19:0] OFS_MAX = 20'hFFFFF,
    parameter logic [15:0] LIN_MAX = 16'hFFFF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          grp_valid,
    input  logic          grp_ready,
    output sts_pkg::grp_t grp
);

    sts_pkg::mode_t mode_reg, mode_next;
    logic [19:0] ofs_reg, ofs_next, beg_reg, beg_next, cnt_reg, cnt_next;
    logic [15:0] line_reg, line_next, pos_reg, pos_next;
    logic [4:0]  kwp_reg, kwp_next;
    logic        quote_reg, quote_next;
    logic [2:0]  pop_reg, pop_next;

    logic          fire;
    sts_pkg::grp_t g;

    assign in_ready  = grp_ready;
    assign fire      = in_valid && in_ready;
    assign grp_valid = fire;
    assign grp       = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::M_IDLE;
            ofs_reg   <= '0;
            beg_reg   <= '0;
            cnt_reg   <= '0;
            line_reg  <= 16'd1;
            pos_reg   <= 16'd1;
            kwp_reg   <= '0;
            quote_reg <= 1'b0;
            pop_reg   <= sts_pkg::P_NONE;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            ofs_reg   <= ofs_next;
            beg_reg   <= beg_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            kwp_reg   <= kwp_next;
            quote_reg <= quote_next;
            pop_reg   <= pop_next;
        end
    end

    // Per-byte scan step, following the pending-token then idle order
    always_comb
    begin
        logic [7:0] c, lc;
        logic       alpha, digit, go_idle, found;
        logic [5:0] ok;
        logic [2:0] p;
        logic [3:0] cand;
        mode_next  = mode_reg;
        ofs_next   = ofs_reg;
        beg_next   = beg_reg;
        cnt_next   = cnt_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;
        kwp_next   = kwp_reg;
        quote_next = quote_reg;
        pop_next   = pop_reg;
        g          = '0;
        c          = in_byte;
        lc         = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        alpha      = (lc >= "a" && lc <= "z") || c == "_" || c == "$";
        digit      = c >= "0" && c <= "9";
        go_idle    = 1'b0;
        ok         = sts_pkg::K_BANG;
        p          = '0;
        cand       = '0;
        found      = 1'b0;

        unique case (mode_reg)
            sts_pkg::M_IDENT:
            begin
                if (alpha || digit)
                begin
                    // keyword tracking
                    p    = (cnt_next > 20'd6) ? 3'd7 : cnt_next[2:0];
                    cand = kwp_next[3:0] - 4'd1;
                    if (kwp_next == 5'd0 || kwp_next > 5'd16)
                        kwp_next = '0;
                    else if (!(p < sts_pkg::kw_len(cand) && sts_pkg::kw_char(cand, p) == lc))
                    begin
                        kwp_next = '0;
                        if (p < 3'd6)
                        begin
                            for (int k = 0; k < 16; k++)
                            begin
                                if (!found && p < sts_pkg::kw_len(4'(k)) &&
                                    sts_pkg::kw_char(4'(k), p) == lc)
                                begin
                                    found = 1'b1;
                                    for (int j = 0; j < 6; j++)
                                        if (3'(j) < p && sts_pkg::kw_char(4'(k), 3'(j)) !=
                                            sts_pkg::kw_char(cand, 3'(j)))
                                            found = 1'b0;
                                    if (found)
                                        kwp_next = 5'(k + 1);
                                end
                            end
                        end
                    end
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                end
                else
                begin
                    g.cnt = 2'd1;
                    g.t0.kind = (kwp_next >= 5'd1 && kwp_next <= 5'd16 &&
                                 cnt_next == 20'(sts_pkg::kw_len(kwp_next[3:0] - 4'd1)))
                              ? sts_pkg::K_KW0 + 6'(kwp_next) - 6'd1 : sts_pkg::K_IDENT;
                    g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                    g.t0.col = (pos_next >= cnt_next[15:0] && cnt_next[19:16] == 4'd0)
                             ? pos_next - cnt_next[15:0] : 16'd0;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::M_NUM, sts_pkg::M_FRAC:
            begin
                if (digit)
                begin
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                end
                else if (c == "." && mode_reg == sts_pkg::M_NUM)
                    mode_next = sts_pkg::M_NUMDOT;
                else
                begin
                    g.cnt = 2'd1;
                    g.t0.kind = sts_pkg::K_NUMBER;
                    g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                    g.t0.col = (pos_next >= cnt_next[15:0] && cnt_next[19:16] == 4'd0)
                             ? pos_next - cnt_next[15:0] : 16'd0;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::M_NUMDOT:
            begin
                if (digit)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                        if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                        if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                    end
                    mode_next = sts_pkg::M_FRAC;
                end
                else
                begin
                    g.cnt = 2'd2;
                    g.t0.kind = sts_pkg::K_NUMBER;
                    g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                    g.t0.col = (pos_next >= cnt_next[15:0] && cnt_next[19:16] == 4'd0)
                             ? pos_next - cnt_next[15:0] : 16'd0;
                    beg_next = ofs_next;
                    cnt_next = 20'd1;
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    g.t1.kind = sts_pkg::K_DOT;
                    g.t1.start = beg_next; g.t1.len = 20'd1; g.t1.line = line_next;
                    g.t1.col = (pos_next >= 16'd1) ? pos_next - 16'd1 : 16'd0;
                    go_idle = 1'b1;
                end
            end
            sts_pkg::M_OP:
            begin
                unique case (pop_reg)
                    sts_pkg::P_EQ: ok = sts_pkg::K_EQ;
                    sts_pkg::P_LT: ok = sts_pkg::K_LT;
                    sts_pkg::P_GT: ok = sts_pkg::K_GT;
                    default:       ok = sts_pkg::K_BANG;
                endcase
                pop_next = sts_pkg::P_NONE;
                if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                if (c == "=")
                begin
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                    ok = ok + 6'd1;
                    mode_next = sts_pkg::M_IDLE;
                end
                else
                    go_idle = 1'b1;
                g.cnt = 2'd1;
                g.t0.kind = ok;
                g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                g.t0.col = (pos_next >= cnt_next[15:0] && cnt_next[19:16] == 4'd0)
                         ? pos_next - cnt_next[15:0] : 16'd0;
            end
            sts_pkg::M_STR:
            begin
                if (c == (quote_reg ? 8'h27 : 8'h22))
                begin
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                    g.cnt = 2'd1;
                    g.t0.kind = sts_pkg::K_STRING;
                    g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                    g.t0.col = (pos_next >= cnt_next[15:0] && cnt_next[19:16] == 4'd0)
                             ? pos_next - cnt_next[15:0] : 16'd0;
                    mode_next = sts_pkg::M_IDLE;
                end
                else if (c == 8'd0)
                begin
                    g.cnt = 2'd1;
                    g.t0.kind = sts_pkg::K_ERR_STR;
                    g.t0.start = beg_next; g.t0.len = cnt_next; g.t0.line = line_next;
                    g.t0.col = (pos_next >= 16'd1) ? pos_next - 16'd1 : 16'd0;
                    go_idle = 1'b1;
                end
                else
                begin
                    if (c == 8'h0A)
                    begin
                        if (line_next < LIN_MAX) line_next = line_next + 16'd1;
                        pos_next = '0;
                    end
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                end
            end
            sts_pkg::M_COMMENT:
            begin
                if (c != 8'h0A && c != 8'd0)
                begin
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                end
                else
                    go_idle = 1'b1;
            end
            default: go_idle = 1'b1;
        endcase

        // Idle handling of the byte, after any pending token
        if (go_idle)
        begin
            mode_next = sts_pkg::M_IDLE;
            if (c == 8'd0)
            begin
                g.t2.kind = sts_pkg::K_EOF;
                g.t2.start = ofs_next; g.t2.len = '0; g.t2.line = line_next;
                g.t2.col = pos_next;
                if (g.cnt == 2'd0) g.t0 = g.t2; else if (g.cnt == 2'd1) g.t1 = g.t2;
                g.cnt = g.cnt + 2'd1;
                ofs_next = '0; beg_next = '0; cnt_next = '0;
                line_next = 16'd1; pos_next = 16'd1;
                kwp_next = '0; quote_next = 1'b0; pop_next = sts_pkg::P_NONE;
            end
            else if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A || c == ";")
            begin
                if (c == 8'h0A)
                begin
                    if (line_next < LIN_MAX) line_next = line_next + 16'd1;
                    pos_next = '0;
                end
                if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                if (cnt_next < OFS_MAX) cnt_next = cnt_next + 20'd1;
                if (c == ";") mode_next = sts_pkg::M_COMMENT;
            end
            else
            begin
                unique case (c)
                    "!":     pop_next = sts_pkg::P_BANG;
                    "=":     pop_next = sts_pkg::P_EQ;
                    "<":     pop_next = sts_pkg::P_LT;
                    ">":     pop_next = sts_pkg::P_GT;
                    default: pop_next = sts_pkg::P_NONE;
                endcase
                beg_next = ofs_next;
                cnt_next = '0;
                if (pop_next != sts_pkg::P_NONE)
                    mode_next = sts_pkg::M_OP;
                else
                begin
                    if (alpha)
                    begin
                        kwp_next = '0;
                        for (int k = 15; k >= 0; k--)
                            if (sts_pkg::kw_char(4'(k), 3'd0) == lc)
                                kwp_next = 5'(k + 1);
                    end
                    if (ofs_next < OFS_MAX) ofs_next = ofs_next + 20'd1;
                    if (pos_next < LIN_MAX) pos_next = pos_next + 16'd1;
                    cnt_next = 20'd1;
                    if (alpha)
                        mode_next = sts_pkg::M_IDENT;
                    else if (digit)
                        mode_next = sts_pkg::M_NUM;
                    else if (c == 8'h27 || c == 8'h22)
                    begin
                        quote_next = (c == 8'h27);
                        mode_next  = sts_pkg::M_STR;
                    end
                    else
                    begin
                        unique case (c)
                            "(":     g.t2.kind = sts_pkg::K_LPAREN;
                            ")":     g.t2.kind = sts_pkg::K_RPAREN;
                            "[":     g.t2.kind = sts_pkg::K_LBRACK;
                            "]":     g.t2.kind = sts_pkg::K_RBRACK;
                            "{":     g.t2.kind = sts_pkg::K_LBRACE;
                            "}":     g.t2.kind = sts_pkg::K_RBRACE;
                            ",":     g.t2.kind = sts_pkg::K_COMMA;
                            ".":     g.t2.kind = sts_pkg::K_DOT;
                            "-":     g.t2.kind = sts_pkg::K_MINUS;
                            "+":     g.t2.kind = sts_pkg::K_PLUS;
                            "/":     g.t2.kind = sts_pkg::K_SLASH;
                            "*":     g.t2.kind = sts_pkg::K_STAR;
                            default: g.t2.kind = sts_pkg::K_ERR_CHAR;
                        endcase
                        g.t2.start = beg_next; g.t2.len = 20'd1; g.t2.line = line_next;
                        g.t2.col = (pos_next >= 16'd1) ? pos_next - 16'd1 : 16'd0;
                        if (g.cnt == 2'd0) g.t0 = g.t2; else if (g.cnt == 2'd1) g.t1 = g.t2;
                        g.cnt = g.cnt + 2'd1;
                    end
                end
            end
        end

        // Mark the last token of this byte
        unique case (g.cnt)
            2'd1:    g.t0.last = 1'b1;
            2'd2:    g.t1.last = 1'b1;
            2'd3:    g.t2.last = 1'b1;
            default: ;
        endcase
    end

    // Three tokens only come from a number split at a dot
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid && grp.cnt == 2'd3) |->
            (grp.t0.kind == sts_pkg::K_NUMBER && grp.t1.kind == sts_pkg::K_DOT))
        else $error("three tokens outside a number and dot split");
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_byte == 8'd0) |=> (ofs_reg == 20'd0 && line_reg == 16'd1))
        else $error("eof did not reset state");
    a_line_nz: assert property (@(posedge clk) disable iff (!rst_n) line_reg != 16'd0)
        else $error("line count zero");

endmodule

@@ hw/rtl/sts_back.sv @@
// Back end: queue of token groups and serialisation onto the output stream.
`timescale 1ns / 1ps

module sts_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          grp_valid,
    output logic          grp_ready,
    input  sts_pkg::grp_t grp,
    output logic          out_valid,
    input  logic          out_ready,
    output sts_pkg::tok_t out_tok
);

    // Four-token ring; a group is taken only when a group of three tokens would fit
    sts_pkg::tok_t q_mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] fill_reg, fill_next;
    logic       pop;
    logic [1:0] n;

    assign n         = grp_valid ? grp.cnt : 2'd0;
    assign grp_ready = fill_reg <= 3'd1 || (fill_reg == 3'd2 && out_ready) ||
                       (fill_reg <= 3'd3 && fill_reg != 3'd0 && 1'b0);
    assign out_valid = fill_reg != 3'd0;
    assign out_tok   = q_mem[rp_reg];
    assign pop       = out_valid && out_ready;
    assign fill_next = fill_reg + 3'(n) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (n >= 2'd1) q_mem[wp_reg]        <= grp.t0;
        if (n >= 2'd2) q_mem[wp_reg + 2'd1] <= grp.t1;
        if (n == 2'd3) q_mem[wp_reg + 2'd2] <= grp.t2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_reg + n;
            rp_reg   <= rp_reg + 2'(pop);
            fill_reg <= fill_next;
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 3'd4)
        else $error("queue overflow");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_reg == $past(fill_next))
        else $error("fill tracking");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == 3'd0 |-> !out_valid)
        else $error("valid with empty queue");

endmodule

@@ hw/rtl/script_token_scanner_unit.sv @@
// Top level of the script token scanner: byte stream in, token stream out.
//
// s_axis carries one source byte per request; byte 0 ends the source, flushes
// any pending token, emits an eof token and returns the scanner to its reset
// state. m_axis carries tokens; tlast marks the last token caused by a byte.
// A byte causes zero to three tokens.
// Throughput: one byte per cycle while the output keeps up. The front end
// accepts a byte only when the four-token queue could take any token group
// (fill of at most one, or two while a token leaves), so bytes that yield
// three tokens hold the input back until the queue drains.
// Tokens enter the queue register as their byte is accepted and leave in order.
// Reset: asynchronous, rst_n low; state returns to line 1, column 1,
// offset 0, and the queue empties.
// Stall: when m_tready is low the queue holds its tokens and s_tready drops
// once two or more tokens wait with none leaving; no token is lost or repeated.
`timescale 1ns / 1ps

module script_token_scanner_unit #(
    parameter longint SOURCE_LIMIT = 1048576,
    parameter longint LINE_LIMIT   = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [5:0] kind, [25:6] start, [45:26] length,
                                   // [61:46] line, [77:62] column, [79:78] zero
    output logic        m_tlast
);

    localparam logic [19:0] OFS_MAX = (SOURCE_LIMIT - 1 < 64'hFFFFF) ?
                                      20'(SOURCE_LIMIT - 1) : 20'hFFFFF;
    localparam logic [15:0] LIN_MAX = (LINE_LIMIT < 64'hFFFF) ?
                                      16'(LINE_LIMIT) : 16'hFFFF;

    sts_pkg::grp_t grp;
    sts_pkg::tok_t tok;
    logic          grp_valid, grp_ready;

    sts_front #(.OFS_MAX(OFS_MAX), .LIN_MAX(LIN_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    sts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    assign m_tdata = {2'b00, tok.col, tok.line, tok.len, tok.start, tok.kind};
    assign m_tlast = tok.last;

endmodule
